>>> rtl/rgbtex_pkg.sv
// Shared types and constants for the RGB24 bitmap to texture pixel converter.
// No dependencies; every rtl file imports this package.
package rgbtex_pkg;

  // Largest image side in pixels; larger register values are clamped to it.
  localparam int unsigned MAX_DIM   = 4096;

  localparam int unsigned DIM_W     = 13;   // width of the size registers
  localparam int unsigned CFG_IDX_W = 2;    // register index width
  localparam int unsigned BCNT_W    = 14;   // bytes within one stored row
  localparam int unsigned POS_W     = 12;   // destination row and column
  localparam int unsigned PIX_W     = 32;   // converted pixel

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_BOTTOM_UP    = 2'd2,
    CFG_OUT_FORMAT   = 2'd3
  } cfg_idx_t;

  // Position of the next pixel byte inside its B,G,R triple.
  typedef enum logic [1:0] {
    PH_BLUE  = 2'd0,
    PH_GREEN = 2'd1,
    PH_RED   = 2'd2
  } phase_t;

  // Frame geometry and format, derived from the configuration registers.
  typedef struct packed {
    logic [DIM_W-1:0]  height;      // clamped row count
    logic [DIM_W-1:0]  h_last;      // height - 1
    logic [BCNT_W-1:0] data_bytes;  // width * 3
    logic [BCNT_W-1:0] pitch;       // data_bytes rounded up to a multiple of four
    logic              bottom_up;
    logic              out_format;  // 0: XRGB8888, 1: ARGB1555
  } geom_t;

  // One converted pixel with its destination.
  typedef struct packed {
    logic [PIX_W-1:0] pixel_value;
    logic [POS_W-1:0] dest_row;
    logic [POS_W-1:0] dest_col;
    logic             target_buffer;
    logic             frame_last;
  } res_t;

endpackage

>>> rtl/rgb24_dib_to_texture_converter.sv
// Top level of the RGB24 bitmap to texture pixel converter: input and result
// registers, handshake, assertions. Depends on rgbtex_pkg, rgbtex_cfg, rgbtex_scan.
//
// Usage:
//   Input channel (in_valid/in_ready/in_src_byte) carries the bitmap one byte
//   per transfer in memory order, B,G,R triples, row padding included.
//   Result channel (out_valid/out_ready/out_*) carries one converted pixel per
//   third pixel byte with its destination row, column, target buffer and a
//   frame_last flag on the final pixel of the frame. Padding bytes and the
//   first two bytes of a pixel give no transfer.
//   Configuration port (cfg_wr_en/cfg_index/cfg_wdata) writes width, height,
//   bottom_up and out_format; write only while the block is idle.
// Timing:
//   An accepted byte is held in the input register, then the scan logic turns
//   it into a result register entry. One byte is accepted every cycle while
//   the result channel is not stalled; the scan logic takes a byte whenever the result register can advance.
// Reset (rst_n, synchronous): registers go to 640 x 480, bottom-up, XRGB8888;
//   counters clear and buffer 0 is shown, so the first frame targets buffer 1.
// Stall: while a result waits on out_ready, one more byte may enter the input
//   register; then in_ready drops until the result transfers.
module rgb24_dib_to_texture_converter (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [rgbtex_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rgbtex_pkg::DIM_W-1:0]     cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [7:0]                       in_src_byte,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [rgbtex_pkg::PIX_W-1:0]     out_pixel_value,
  output logic [rgbtex_pkg::POS_W-1:0]     out_dest_row,
  output logic [rgbtex_pkg::POS_W-1:0]     out_dest_col,
  output logic                             out_target_buffer,
  output logic                             out_frame_last
);
  import rgbtex_pkg::*;

  geom_t       geom;
  res_t        scan_res;
  logic        scan_produced;

  logic        s1_valid_r, s1_valid_nxt;
  logic [7:0]  s1_byte_r, s1_byte_nxt;
  logic        out_valid_r, out_valid_nxt;
  res_t        out_res_r, out_res_nxt;

  logic        adv;    // result register free or emptied this cycle
  logic        step;   // input register item consumed by the scan logic

  rgbtex_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .geom      (geom)
  );

  rgbtex_scan u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .src_byte (s1_byte_r),
    .geom     (geom),
    .produced (scan_produced),
    .result   (scan_res)
  );

  always_comb begin
    adv      = !out_valid_r || out_ready;
    step     = s1_valid_r && adv;
    in_ready = !s1_valid_r || adv;
  end

  // Input register: load on a transfer, drop once consumed.
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_byte_nxt  = s1_byte_r;
    if (in_valid && in_ready) begin
      s1_valid_nxt = 1'b1;
      s1_byte_nxt  = in_src_byte;
    end else if (step) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // Result register: advance whenever it is free or being taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (adv) begin
      out_valid_nxt = step && scan_produced;
      if (step && scan_produced) begin
        out_res_nxt = scan_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_byte_r <= s1_byte_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_pixel_value   = out_res_r.pixel_value;
  assign out_dest_row      = out_res_r.dest_row;
  assign out_dest_col      = out_res_r.dest_col;
  assign out_target_buffer = out_res_r.target_buffer;
  assign out_frame_last    = out_res_r.frame_last;

  // A result only appears after an item sat in the input register.
  a_result_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r))
    else $error("result appeared without an input register item");

  // A blocked input register item holds its byte.
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !adv) |=> (s1_valid_r && $stable(s1_byte_r)))
    else $error("input register item lost while result stalled");

  // Every result carries a well-formed pixel in one of the two formats.
  a_pixel_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_res_r.pixel_value[31:24] == 8'hFF) ||
                     (out_res_r.pixel_value[31:15] == 17'h00001)))
    else $error("malformed pixel value");

endmodule

>>> rtl/rgbtex_cfg.sv
// Configuration registers and derived frame geometry.
// Depends on rgbtex_pkg.
module rgbtex_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [rgbtex_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rgbtex_pkg::DIM_W-1:0]     cfg_wdata,
  output rgbtex_pkg::geom_t                geom
);
  import rgbtex_pkg::*;

  logic [DIM_W-1:0] width_r, width_nxt;
  logic [DIM_W-1:0] height_r, height_nxt;
  logic             bottom_up_r, bottom_up_nxt;
  logic             out_format_r, out_format_nxt;

  logic [DIM_W-1:0]  w_c;
  logic [DIM_W-1:0]  h_c;
  logic [BCNT_W:0]   db_sum;
  logic [BCNT_W:0]   pitch_sum;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

  always_comb begin
    width_nxt      = width_r;
    height_nxt     = height_r;
    bottom_up_nxt  = bottom_up_r;
    out_format_nxt = out_format_r;
    if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_IMAGE_WIDTH:  width_nxt      = cfg_wdata;
        CFG_IMAGE_HEIGHT: height_nxt     = cfg_wdata;
        CFG_BOTTOM_UP:    bottom_up_nxt  = cfg_wdata[0];
        CFG_OUT_FORMAT:   out_format_nxt = cfg_wdata[0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r      <= DIM_W'(640);
      height_r     <= DIM_W'(480);
      bottom_up_r  <= 1'b1;
      out_format_r <= 1'b0;
    end else begin
      width_r      <= width_nxt;
      height_r     <= height_nxt;
      bottom_up_r  <= bottom_up_nxt;
      out_format_r <= out_format_nxt;
    end
  end

  always_comb begin
    w_c       = clamp_dim(width_r);
    h_c       = clamp_dim(height_r);
    // width * 3 as width + 2 * width
    db_sum    = {2'b00, w_c} + {1'b0, w_c, 1'b0};
    pitch_sum = (db_sum + (BCNT_W+1)'(3)) & ~((BCNT_W+1)'(3));

    geom.height     = h_c;
    geom.h_last     = h_c - DIM_W'(1);
    geom.data_bytes = db_sum[BCNT_W-1:0];
    geom.pitch      = pitch_sum[BCNT_W-1:0];
    geom.bottom_up  = bottom_up_r;
    geom.out_format = out_format_r;
  end

endmodule

>>> rtl/rgbtex_scan.sv
// Raster scan state and pixel assembly: byte phase, row/column counters,
// buffer toggle and pixel formatting. Depends on rgbtex_pkg.
module rgbtex_scan (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        src_byte,
  input  rgbtex_pkg::geom_t geom,
  output logic              produced,
  output rgbtex_pkg::res_t  result
);
  import rgbtex_pkg::*;

  phase_t             phase_r, phase_nxt;
  logic [15:0]        held_r, held_nxt;
  logic [BCNT_W-1:0]  rbc_r, rbc_nxt;
  logic [POS_W-1:0]   col_r, col_nxt;
  logic [POS_W-1:0]   row_r, row_nxt;
  logic               front_r, front_nxt;

  logic [BCNT_W:0]    rbc_inc;
  logic               pix_byte;
  logic               row_end;
  logic               last_row;
  logic [DIM_W-1:0]   row_ext;
  logic [DIM_W-1:0]   drow;

  always_comb begin
    rbc_inc  = {1'b0, rbc_r} + (BCNT_W+1)'(1);
    pix_byte = (rbc_r < geom.data_bytes);
    row_end  = (rbc_inc >= {1'b0, geom.pitch});
    row_ext  = {1'b0, row_r};
    last_row = (row_ext >= geom.h_last);
  end

  // Byte phase: blue, green, red; a row end restarts at blue.
  always_comb begin
    phase_nxt = phase_r;
    if (step) begin
      if (row_end) begin
        phase_nxt = PH_BLUE;
      end else if (pix_byte) begin
        unique case (phase_r)
          PH_BLUE:  phase_nxt = PH_GREEN;
          PH_GREEN: phase_nxt = PH_RED;
          PH_RED:   phase_nxt = PH_BLUE;
          default:  phase_nxt = PH_BLUE;
        endcase
      end
    end
  end

  // Datapath and counters.
  always_comb begin
    held_nxt  = held_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    rbc_nxt   = rbc_r;
    front_nxt = front_r;
    produced  = 1'b0;

    if (geom.bottom_up) begin
      drow = (row_ext < geom.height) ? (geom.h_last - row_ext) : '0;
    end else begin
      drow = row_ext;
    end

    if (geom.out_format) begin
      result.pixel_value = {16'h0000, 1'b1, src_byte[7:3], held_r[15:11], held_r[7:3]};
    end else begin
      result.pixel_value = {8'hFF, src_byte, held_r[15:8], held_r[7:0]};
    end
    result.dest_row      = drow[POS_W-1:0];
    result.dest_col      = col_r;
    result.target_buffer = ~front_r;
    result.frame_last    = last_row && (rbc_inc >= {1'b0, geom.data_bytes});

    if (step) begin
      if (pix_byte) begin
        unique case (phase_r)
          PH_BLUE:  held_nxt = {held_r[15:8], src_byte};
          PH_GREEN: held_nxt = {src_byte, held_r[7:0]};
          default: begin
            produced = 1'b1;
            col_nxt  = col_r + POS_W'(1);
          end
        endcase
      end
      if (row_end) begin
        rbc_nxt = '0;
        col_nxt = '0;
        if (last_row) begin
          row_nxt   = '0;
          front_nxt = ~front_r;
        end else begin
          row_nxt = row_r + POS_W'(1);
        end
      end else begin
        rbc_nxt = rbc_inc[BCNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_BLUE;
      held_r  <= '0;
      rbc_r   <= '0;
      col_r   <= '0;
      row_r   <= '0;
      front_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
      rbc_r   <= rbc_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      front_r <= front_nxt;
    end
  end

endmodule
